// ----- rtl/plc_tb_pkg.sv -----
// Shared types and constants for the PLC timer bank.
`default_nettype none
package plc_tb_pkg;

  localparam int unsigned NumTimers = 256;
  localparam int unsigned IdxW      = 8;
  localparam int unsigned PresetW   = 16;
  localparam int unsigned ValueOutW = 16;

  localparam logic [7:0] GrpMidLo   = 8'd200;
  localparam logic [7:0] GrpFastLo  = 8'd246;
  localparam logic [7:0] GrpHSlowLo = 8'd250;
  localparam logic [7:0] GrpFastHi  = 8'd249;
  localparam logic [7:0] GrpLastIdx = 8'd255;
  localparam logic [7:0] GrpFirst   = 8'd0;
  localparam logic [6:0] PhaseMax   = 7'd99;
  localparam logic [6:0] PhaseSlow  = 7'd50;
  localparam logic [6:0] PhaseHSlow = 7'd90;
  localparam logic [9:0] TenthsHalf = 10'd300;
  localparam logic [9:0] TenthsMax  = 10'd599;
  localparam logic [3:0] DigitMax   = 4'd9;
  localparam logic [3:0] Digit10ms  = 4'd7;
  localparam logic [3:0] DigitSet10 = 4'd2;
  localparam logic [3:0] DigitHalf  = 4'd5;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [IdxW-1:0]      idx;
    logic [PresetW-1:0]   preset;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/plc_tb_if.sv -----
// Handshake channels for command beats and result beats.
`default_nettype none
interface plc_tb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  timer_index;
  logic [15:0] preset;
  modport source(output valid, output op, output timer_index, output preset, input ready);
  modport sink(input valid, input op, input timer_index, input preset, output ready);
endinterface

interface plc_tb_out_if;
  logic        valid;
  logic        ready;
  logic        done_res;
  logic [15:0] current_value;
  logic        clk_10ms;
  logic        clk_100ms;
  logic        clk_1s;
  logic        clk_1min;
  logic [15:0] ms_count;
  modport source(output valid, output done_res, output current_value, output clk_10ms,
                 output clk_100ms, output clk_1s, output clk_1min, output ms_count,
                 input ready);
  modport sink(input valid, input done_res, input current_value, input clk_10ms,
               input clk_100ms, input clk_1s, input clk_1min, input ms_count,
               output ready);
endinterface
`default_nettype wire

// ----- rtl/plc_tb_front.sv -----
// Front end: takes command beats, classifies the operation and queues them.
`default_nettype none
module plc_tb_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire [1:0]           op_i,
  input  wire [7:0]           timer_index_i,
  input  wire [15:0]          preset_i,
  output logic                cmd_valid_o,
  input  wire                 cmd_ready_i,
  output plc_tb_pkg::cmd_t    cmd_o
);

  plc_tb_pkg::cmd_t q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  plc_tb_pkg::cmd_t cmd_new;

  always_comb begin
    cmd_new.idx    = timer_index_i;
    cmd_new.preset = preset_i;
    case (op_i)
      plc_tb_pkg::OP_TICK:  cmd_new.op = plc_tb_pkg::OP_TICK;
      plc_tb_pkg::OP_START: cmd_new.op = plc_tb_pkg::OP_START;
      plc_tb_pkg::OP_STOP:  cmd_new.op = plc_tb_pkg::OP_STOP;
      default:              cmd_new.op = plc_tb_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_new;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/plc_tb_back.sv -----
// Back end: time base, timer sweep over the value memory, and result register.
`default_nettype none
module plc_tb_back #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cmd_valid_i,
  output logic                cmd_ready_o,
  input  plc_tb_pkg::cmd_t    cmd_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic                done_res_o,
  output logic [15:0]         current_value_o,
  output logic [3:0]          clk_bits_o,
  output logic [15:0]         ms_count_o
);

  localparam int unsigned NT = plc_tb_pkg::NumTimers;
  localparam int unsigned IW = plc_tb_pkg::IdxW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SWEEP, ST_DRAIN, ST_READ, ST_RESULT, ST_OUT
  } state_e;

  state_e state_q;
  plc_tb_pkg::cmd_t cmd_q;
  logic [6:0]  phase_q;
  logic [3:0]  ph_lo_q;
  logic [9:0]  tenths_q;
  logic [3:0]  tn_lo_q;
  logic [3:0]  clk_bits_q;
  logic [15:0] ms_q;
  logic [IW-1:0] t_q, hi_q, s1_addr_q;
  logic          mid_q, slow_q, hs_q, s1_vld_q;
  logic [NT-1:0] en_q, vld_q;
  logic          done_q, out_valid_q;
  logic [15:0]   cur_q;

  logic [VALUE_WIDTH-1:0] val_mem [NT];
  logic [VALUE_WIDTH-1:0] pre_mem [NT];
  logic [VALUE_WIDTH-1:0] val_rd_q, pre_rd_q;
  logic [IW-1:0]          rd_addr;
  logic                   val_we, pre_we;
  logic [IW-1:0]          val_wa;
  logic [VALUE_WIDTH-1:0] val_wd, pre_wd;

  logic [6:0]  ph_inc, ph_n;
  logic [3:0]  lo_n, tnlo_n;
  logic [9:0]  tn_n, tn_store;
  logic [3:0]  cb_n;
  logic        mid_n, slow_n, hs_n;
  logic [IW-1:0] sweep_lo, sweep_hi;
  logic [VALUE_WIDTH-1:0] s1_val, res_val, new_pre;
  logic        s1_step, grp_hit;
  logic        pop;

  assign pop         = cmd_valid_i && (state_q == ST_IDLE);
  assign cmd_ready_o = (state_q == ST_IDLE);

  always_comb begin
    ph_inc = phase_q + 7'd1;
    lo_n   = (ph_lo_q == plc_tb_pkg::DigitMax) ? 4'd0 : ph_lo_q + 4'd1;
    cb_n   = clk_bits_q;
    if (ph_inc > plc_tb_pkg::PhaseMax) begin
      ph_n     = 7'd0;
      cb_n[1]  = 1'b1;
    end else begin
      ph_n = ph_inc;
    end
    mid_n = (lo_n == plc_tb_pkg::Digit10ms);
    if (mid_n) cb_n[0] = 1'b0;
    if (lo_n == plc_tb_pkg::DigitSet10) cb_n[0] = 1'b1;
    slow_n = (ph_n == plc_tb_pkg::PhaseSlow);
    if (slow_n) cb_n[1] = 1'b0;
    hs_n   = (ph_n == plc_tb_pkg::PhaseHSlow);
    tn_n   = tenths_q + {9'd0, hs_n};
    tnlo_n = hs_n ? ((tn_lo_q == plc_tb_pkg::DigitMax) ? 4'd0 : tn_lo_q + 4'd1) : tn_lo_q;
    if (tnlo_n == plc_tb_pkg::DigitHalf) cb_n[2] = 1'b0;
    if (tnlo_n == 4'd0) cb_n[2] = 1'b1;
    if (tn_n == plc_tb_pkg::TenthsHalf) cb_n[3] = 1'b0;
    if (tn_n == 10'd0) cb_n[3] = 1'b1;
    tn_store = (tn_n > plc_tb_pkg::TenthsMax) ? 10'd0 : tn_n;
    sweep_lo = slow_n ? plc_tb_pkg::GrpFirst :
               (mid_n ? plc_tb_pkg::GrpMidLo : plc_tb_pkg::GrpFastLo);
    sweep_hi = hs_n ? plc_tb_pkg::GrpLastIdx : plc_tb_pkg::GrpFastHi;
  end

  always_comb begin
    grp_hit = ((s1_addr_q >= plc_tb_pkg::GrpFastLo) && (s1_addr_q < plc_tb_pkg::GrpHSlowLo))
           || (mid_q && (s1_addr_q >= plc_tb_pkg::GrpMidLo)
                     && (s1_addr_q < plc_tb_pkg::GrpFastLo))
           || (slow_q && (s1_addr_q < plc_tb_pkg::GrpMidLo))
           || (hs_q && (s1_addr_q >= plc_tb_pkg::GrpHSlowLo));
    s1_val  = vld_q[s1_addr_q] ? val_rd_q : '0;
    s1_step = s1_vld_q && grp_hit && en_q[s1_addr_q] && (s1_val < pre_rd_q);
    res_val = vld_q[cmd_q.idx] ? val_rd_q : '0;
    new_pre = VALUE_WIDTH'(cmd_q.preset);
    rd_addr = (state_q == ST_READ) ? cmd_q.idx : t_q;
    val_we  = 1'b0;
    val_wa  = s1_addr_q;
    val_wd  = s1_val + VALUE_WIDTH'(1);
    pre_we  = 1'b0;
    pre_wd  = new_pre;
    if ((state_q == ST_SWEEP || state_q == ST_DRAIN) && s1_step) begin
      val_we = 1'b1;
    end
    if (state_q == ST_RESULT) begin
      val_wa = cmd_q.idx;
      if (cmd_q.op == plc_tb_pkg::OP_STOP) begin
        val_we = 1'b1;
        val_wd = '0;
        pre_we = 1'b1;
        pre_wd = '0;
      end
      if (cmd_q.op == plc_tb_pkg::OP_START) begin
        pre_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (pre_we) begin
      pre_mem[val_wa] <= pre_wd;
    end
    val_rd_q <= val_mem[rd_addr];
    pre_rd_q <= pre_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      phase_q     <= '0;
      ph_lo_q     <= '0;
      tenths_q    <= '0;
      tn_lo_q     <= '0;
      clk_bits_q  <= '0;
      ms_q        <= '0;
      t_q         <= '0;
      hi_q        <= '0;
      s1_addr_q   <= '0;
      mid_q       <= 1'b0;
      slow_q      <= 1'b0;
      hs_q        <= 1'b0;
      s1_vld_q    <= 1'b0;
      en_q        <= '0;
      vld_q       <= '0;
      done_q      <= 1'b0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (val_we) vld_q[val_wa] <= 1'b1;
      case (state_q)
        ST_IDLE: begin
          if (pop) begin
            cmd_q <= cmd_i;
            if (cmd_i.op == plc_tb_pkg::OP_TICK) begin
              ms_q       <= ms_q + 16'd1;
              phase_q    <= ph_n;
              ph_lo_q    <= lo_n;
              tenths_q   <= tn_store;
              tn_lo_q    <= tnlo_n;
              clk_bits_q <= cb_n;
              mid_q      <= mid_n;
              slow_q     <= slow_n;
              hs_q       <= hs_n;
              t_q        <= sweep_lo;
              hi_q       <= sweep_hi;
              state_q    <= ST_SWEEP;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        ST_SWEEP: begin
          s1_vld_q  <= 1'b1;
          s1_addr_q <= t_q;
          if (t_q == hi_q) begin
            state_q <= ST_DRAIN;
          end else begin
            t_q <= t_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          s1_vld_q <= 1'b0;
          state_q  <= ST_READ;
        end
        ST_READ: begin
          state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          done_q <= 1'b0;
          cur_q  <= 16'(res_val);
          case (cmd_q.op)
            plc_tb_pkg::OP_START: begin
              en_q[cmd_q.idx] <= 1'b1;
              done_q          <= (res_val >= new_pre);
            end
            plc_tb_pkg::OP_STOP: begin
              en_q[cmd_q.idx] <= 1'b0;
              cur_q           <= '0;
            end
            default: begin
            end
          endcase
          out_valid_q <= 1'b1;
          state_q     <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign done_res_o      = done_q;
  assign current_value_o = cur_q;
  assign clk_bits_o      = clk_bits_q;
  assign ms_count_o      = ms_q;

`ifndef SYNTHESIS
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (t_q <= hi_q))
    else $error("sweep address beyond range end");
  a_stage_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> (state_q == ST_SWEEP || state_q == ST_DRAIN))
    else $error("sweep stage live outside a sweep");
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == ST_OUT))
    else $error("result shown outside output state");
  a_ms_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cmd_i.op == plc_tb_pkg::OP_TICK) |=> (ms_q == $past(ms_q) + 16'd1))
    else $error("millisecond counter did not advance on a tick");
`endif

endmodule
`default_nettype wire

// ----- rtl/plc_timer_bank_core.sv -----
// Top level of the PLC on-delay timer bank.
`default_nettype none
// A bank of 256 on-delay timers driven by 1 ms tick beats, with a two-entry
// command queue in front of a sequencer that owns the timer memories. A tick
// walks the timer groups due at the new phase, one timer per cycle through
// the value and preset memories; the widest walk covers timers 0 to 249.
// Start, stop and idle operations go straight to the read, result and output
// states. One result beat follows every command beat.
module plc_timer_bank_core #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  plc_tb_in_if.sink   in_i,
  plc_tb_out_if.source out_o
);

  logic             cmd_valid, cmd_ready;
  plc_tb_pkg::cmd_t cmd;
  logic [3:0]       clk_bits;

  plc_tb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .op_i         (in_i.op),
    .timer_index_i(in_i.timer_index),
    .preset_i     (in_i.preset),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  plc_tb_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_ready_o    (cmd_ready),
    .cmd_i          (cmd),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .done_res_o     (out_o.done_res),
    .current_value_o(out_o.current_value),
    .clk_bits_o     (clk_bits),
    .ms_count_o     (out_o.ms_count)
  );

  assign out_o.clk_10ms  = clk_bits[0];
  assign out_o.clk_100ms = clk_bits[1];
  assign out_o.clk_1s    = clk_bits[2];
  assign out_o.clk_1min  = clk_bits[3];

endmodule
`default_nettype wire
